### rtl/core/audio_buffer_playtime_queue_macros.svh
// Assertion macros used by the play-time queue RTL.
`ifndef AUDIO_BUFFER_PLAYTIME_QUEUE_MACROS_SVH
`define AUDIO_BUFFER_PLAYTIME_QUEUE_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ABPQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ABPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/abpq_pkg.sv
// Types, constants and lookup functions of the audio play-time queue.
package abpq_pkg;

    localparam int ID_W        = 32;
    localparam int BYTES_W     = 18;
    localparam int TICKS_W     = 24;
    localparam int DIVIDEND_W  = 28;
    localparam int DIVISOR_W   = 16;
    localparam int STEP_W      = 5;
    localparam int MAX_BYTES_W = 21;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [TICKS_W-1:0]    TICK_MAX = {TICKS_W{1'b1}};
    localparam logic [DIVIDEND_W-1:0] MS_PER_S = DIVIDEND_W'(1000);

    localparam logic [1:0] KIND_SUBMIT = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;

    localparam logic [1:0] REG_RATE_CODE       = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT   = 2'd1;
    localparam logic [1:0] REG_SAMPLE_ENCODING = 2'd2;
    localparam logic [1:0] REG_UNIT_DIRECTION  = 2'd3;

    localparam logic [1:0] DIR_PLAY   = 2'd0;
    localparam logic [1:0] DIR_RECORD = 2'd1;

    localparam logic [1:0] ENC_PCM16 = 2'd1;
    localparam logic [1:0] ENC_PCM24 = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] bytes;
        logic [TICKS_W-1:0] ticks;
    } queue_entry_t;

    function automatic logic [DIVISOR_W-1:0] rate_hz(input logic [3:0] code);
        logic [DIVISOR_W-1:0] hz;
        case (code)
            4'd0:    hz = 16'd7350;
            4'd1:    hz = 16'd8000;
            4'd2:    hz = 16'd8820;
            4'd3:    hz = 16'd9600;
            4'd4:    hz = 16'd11025;
            4'd5:    hz = 16'd12000;
            4'd6:    hz = 16'd14700;
            4'd7:    hz = 16'd16000;
            4'd8:    hz = 16'd22050;
            4'd9:    hz = 16'd24000;
            4'd10:   hz = 16'd29400;
            4'd11:   hz = 16'd32000;
            4'd12:   hz = 16'd44100;
            default: hz = 16'd48000;
        endcase
        return hz;
    endfunction

    // Unknown encodings count as one byte per sample.
    function automatic logic [1:0] bytes_per_sample(input logic [1:0] enc);
        logic [1:0] bps;
        case (enc)
            ENC_PCM16: bps = 2'd2;
            ENC_PCM24: bps = 2'd3;
            default:   bps = 2'd1;
        endcase
        return bps;
    endfunction

endpackage

### rtl/core/abpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module abpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

### rtl/core/audio_buffer_playtime_queue.sv
// Top level of the audio buffer play-time pacing queue.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+-----------------------------------------
//  cfg      | in/out    | psel/penable       | rate, channels, encoding, unit direction
//  input    | in        | in_valid/in_stall  | kind, transfer_id, num_bytes
//  result   | out       | out_valid/out_stall| done_id, done_bytes, done_direction, status
//
// A queued submit uses one restoring divider, one quotient bit per cycle, which
// runs 18 steps for the channel and sample-size division and 28 steps for the rate.
// A rejected submit goes straight to the emit state, and a tick that only counts down stays idle.
// A completion reads the head entry, then the next entry if one remains, and may wait on a stalled output.
// Reset clears the control state only; queue storage holds nothing valid until written.
// A stalled result only holds the sequencer when a further result is ready to go out.
module audio_buffer_playtime_queue #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int TICKS_PER_MS = 1,
    parameter int MAX_BYTES    = 204800
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [abpq_pkg::ADDR_W-1:0]       paddr,
    input  logic [abpq_pkg::DATA_W-1:0]       pwdata,
    output logic [abpq_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic [abpq_pkg::ID_W-1:0]         transfer_id,
    input  logic [abpq_pkg::BYTES_W-1:0]      num_bytes,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [abpq_pkg::ID_W-1:0]         done_id,
    output logic [abpq_pkg::BYTES_W-1:0]      done_bytes,
    output logic                              done_direction,
    output logic                              done_status
);

    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int TPM_W    = $clog2(TICKS_PER_MS + 1);
    localparam int SCALED_W = abpq_pkg::DIVIDEND_W + TPM_W;
    localparam int ENTRY_W  = $bits(abpq_pkg::queue_entry_t);

    localparam logic [CNT_W-1:0]   FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]   LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]     DEPTH_WIDE = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [TPM_W-1:0]   TPM_L      = TPM_W'(TICKS_PER_MS);
    localparam logic [abpq_pkg::MAX_BYTES_W-1:0] MAX_BYTES_L =
        abpq_pkg::MAX_BYTES_W'(MAX_BYTES);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_DIV_CH    = 10'b00_0000_0010,
        ST_MUL_MS    = 10'b00_0000_0100,
        ST_DIV_RATE  = 10'b00_0000_1000,
        ST_SCALE     = 10'b00_0001_0000,
        ST_WRITE     = 10'b00_0010_0000,
        ST_HEAD_DATA = 10'b00_0100_0000,
        ST_NEXT_WAIT = 10'b00_1000_0000,
        ST_NEXT_DATA = 10'b01_0000_0000,
        ST_EMIT      = 10'b10_0000_0000
    } state_t;

    // Control state.
    state_t                          state_reg, state_next;
    logic [PTR_W-1:0]                head_reg, head_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [abpq_pkg::TICKS_W-1:0]    ticks_rem_reg, ticks_rem_next;
    logic                            active_reg, active_next;
    logic                            out_valid_reg, out_valid_next;
    logic [abpq_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [3:0]                      rate_code_reg;
    logic [1:0]                      channel_count_reg;
    logic [1:0]                      sample_encoding_reg;
    logic [1:0]                      unit_direction_reg;

    // Datapath.
    logic [abpq_pkg::DIVIDEND_W-1:0] div_q_reg, div_q_next;
    logic [abpq_pkg::DIVISOR_W-1:0]  div_r_reg, div_r_next;
    logic [abpq_pkg::DIVISOR_W-1:0]  div_d_reg, div_d_next;
    logic [SCALED_W-1:0]             scaled_reg, scaled_next;
    logic [abpq_pkg::ID_W-1:0]       id_hold_reg, id_hold_next;
    logic [abpq_pkg::BYTES_W-1:0]    bytes_hold_reg, bytes_hold_next;
    logic [abpq_pkg::ID_W-1:0]       res_id_reg, res_id_next;
    logic [abpq_pkg::BYTES_W-1:0]    res_bytes_reg, res_bytes_next;
    logic                            res_dir_reg, res_dir_next;
    logic                            res_status_reg, res_status_next;
    logic [abpq_pkg::ID_W-1:0]       done_id_reg, done_id_next;
    logic [abpq_pkg::BYTES_W-1:0]    done_bytes_reg, done_bytes_next;
    logic                            done_dir_reg, done_dir_next;
    logic                            done_status_reg, done_status_next;

    logic                            cfg_wr;
    logic [1:0]                      cfg_index;
    logic [abpq_pkg::BYTES_W-1:0]    bytes_clamped;
    logic [1:0]                      channels_eff;
    logic [3:0]                      small_divisor;
    logic [abpq_pkg::DIVISOR_W:0]    div_shifted;
    logic [abpq_pkg::DIVISOR_W:0]    div_diff;
    logic                            div_ge;
    logic [abpq_pkg::DIVIDEND_W-1:0] ms_scaled;
    logic [abpq_pkg::TICKS_W-1:0]    ticks_sat;
    logic [PTR_W:0]                  tail_sum;
    logic [PTR_W-1:0]                tail_slot;
    logic [PTR_W-1:0]                head_inc;
    logic                            suppress;
    logic                            ram_wr_en;
    abpq_pkg::queue_entry_t          ram_wr_data;
    abpq_pkg::queue_entry_t          ram_rd_data;
    logic [ENTRY_W-1:0]              ram_rd_bits;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_code_reg       <= 4'd13;
            channel_count_reg   <= 2'd2;
            sample_encoding_reg <= 2'd1;
            unit_direction_reg  <= abpq_pkg::DIR_PLAY;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                abpq_pkg::REG_RATE_CODE:       rate_code_reg       <= pwdata[3:0];
                abpq_pkg::REG_CHANNEL_COUNT:   channel_count_reg   <= pwdata[1:0];
                abpq_pkg::REG_SAMPLE_ENCODING: sample_encoding_reg <= pwdata[1:0];
                abpq_pkg::REG_UNIT_DIRECTION:  unit_direction_reg  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            abpq_pkg::REG_RATE_CODE:       prdata = abpq_pkg::DATA_W'(rate_code_reg);
            abpq_pkg::REG_CHANNEL_COUNT:   prdata = abpq_pkg::DATA_W'(channel_count_reg);
            abpq_pkg::REG_SAMPLE_ENCODING: prdata = abpq_pkg::DATA_W'(sample_encoding_reg);
            abpq_pkg::REG_UNIT_DIRECTION:  prdata = abpq_pkg::DATA_W'(unit_direction_reg);
            default:                       prdata = '0;
        endcase
    end

    // Submit preprocessing. Dividing by channels and then by sample size equals one
    // division by their product, which is at most nine.
    assign bytes_clamped = (abpq_pkg::MAX_BYTES_W'(num_bytes) > MAX_BYTES_L)
                         ? abpq_pkg::BYTES_W'(MAX_BYTES) : num_bytes;
    assign channels_eff  = (channel_count_reg == 2'd0) ? 2'd1 : channel_count_reg;
    assign small_divisor = {2'b00, channels_eff}
                         * {2'b00, abpq_pkg::bytes_per_sample(sample_encoding_reg)};

    // Shared restoring divider step.
    assign div_shifted = {div_r_reg, div_q_reg[abpq_pkg::DIVIDEND_W-1]};
    assign div_diff    = div_shifted - {1'b0, div_d_reg};
    assign div_ge      = div_shifted >= {1'b0, div_d_reg};

    assign ms_scaled = abpq_pkg::DIVIDEND_W'(div_q_reg[abpq_pkg::BYTES_W-1:0])
                     * abpq_pkg::MS_PER_S;
    assign ticks_sat = (scaled_reg > SCALED_W'(abpq_pkg::TICK_MAX))
                     ? abpq_pkg::TICK_MAX : scaled_reg[abpq_pkg::TICKS_W-1:0];

    // Queue pointers; the sum stays below twice the depth.
    assign tail_sum  = {1'b0, head_reg} + {1'b0, count_reg[PTR_W-1:0]};
    assign tail_slot = (tail_sum >= DEPTH_WIDE) ? PTR_W'(tail_sum - DEPTH_WIDE)
                                                : tail_sum[PTR_W-1:0];
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign suppress  = unit_direction_reg > abpq_pkg::DIR_RECORD;

    assign ram_wr_en         = (state_reg == ST_WRITE);
    assign ram_wr_data.id    = id_hold_reg;
    assign ram_wr_data.bytes = bytes_hold_reg;
    assign ram_wr_data.ticks = ticks_sat;
    assign ram_rd_data       = abpq_pkg::queue_entry_t'(ram_rd_bits);

    // The read port always follows the head, so its data is the head entry in the cycle
    // after the head pointer settles.
    abpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_slot),
        .wr_data (ram_wr_data),
        .rd_addr (head_reg),
        .rd_data (ram_rd_bits)
    );

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        ticks_rem_next   = ticks_rem_reg;
        active_next      = active_reg;
        step_next        = step_reg;
        div_q_next       = div_q_reg;
        div_r_next       = div_r_reg;
        div_d_next       = div_d_reg;
        scaled_next      = scaled_reg;
        id_hold_next     = id_hold_reg;
        bytes_hold_next  = bytes_hold_reg;
        res_id_next      = res_id_reg;
        res_bytes_next   = res_bytes_reg;
        res_dir_next     = res_dir_reg;
        res_status_next  = res_status_reg;
        done_id_next     = done_id_reg;
        done_bytes_next  = done_bytes_reg;
        done_dir_next    = done_dir_reg;
        done_status_next = done_status_reg;
        out_valid_next   = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind)
                        abpq_pkg::KIND_SUBMIT:
                        begin
                            id_hold_next    = transfer_id;
                            bytes_hold_next = bytes_clamped;
                            if (count_reg == FULL_COUNT)
                            begin
                                res_id_next     = transfer_id;
                                res_bytes_next  = bytes_clamped;
                                res_dir_next    = (unit_direction_reg == abpq_pkg::DIR_RECORD);
                                res_status_next = 1'b1;
                                state_next      = ST_EMIT;
                            end
                            else
                            begin
                                div_q_next = {bytes_clamped,
                                    (abpq_pkg::DIVIDEND_W - abpq_pkg::BYTES_W)'(0)};
                                div_r_next = '0;
                                div_d_next = abpq_pkg::DIVISOR_W'(small_divisor);
                                step_next  = abpq_pkg::STEP_W'(abpq_pkg::BYTES_W);
                                state_next = ST_DIV_CH;
                            end
                        end
                        abpq_pkg::KIND_TICK:
                        begin
                            if (active_reg)
                            begin
                                if (ticks_rem_reg <= abpq_pkg::TICKS_W'(1))
                                begin
                                    state_next = ST_HEAD_DATA;
                                end
                                else
                                begin
                                    ticks_rem_next = ticks_rem_reg - 1'b1;
                                end
                            end
                        end
                        abpq_pkg::KIND_STOP:
                        begin
                            if (active_reg)
                            begin
                                state_next = ST_HEAD_DATA;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV_CH, ST_DIV_RATE:
            begin
                div_q_next = {div_q_reg[abpq_pkg::DIVIDEND_W-2:0], div_ge};
                div_r_next = div_ge ? div_diff[abpq_pkg::DIVISOR_W-1:0]
                                    : div_shifted[abpq_pkg::DIVISOR_W-1:0];
                step_next  = step_reg - 1'b1;
                if (step_reg == abpq_pkg::STEP_W'(1))
                begin
                    state_next = (state_reg == ST_DIV_CH) ? ST_MUL_MS : ST_SCALE;
                end
            end
            ST_MUL_MS:
            begin
                div_q_next = ms_scaled;
                div_r_next = '0;
                div_d_next = abpq_pkg::rate_hz(rate_code_reg);
                step_next  = abpq_pkg::STEP_W'(abpq_pkg::DIVIDEND_W);
                state_next = ST_DIV_RATE;
            end
            ST_SCALE:
            begin
                scaled_next = SCALED_W'(div_q_reg) * SCALED_W'(TPM_L);
                state_next  = ST_WRITE;
            end
            ST_WRITE:
            begin
                count_next = count_reg + 1'b1;
                if (!active_reg)
                begin
                    ticks_rem_next = ticks_sat;
                    active_next    = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_HEAD_DATA:
            begin
                res_id_next     = ram_rd_data.id;
                res_bytes_next  = ram_rd_data.bytes;
                res_dir_next    = unit_direction_reg[0];
                res_status_next = 1'b0;
                head_next       = head_inc;
                count_next      = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    ticks_rem_next = '0;
                    active_next    = 1'b0;
                    state_next     = suppress ? ST_IDLE : ST_EMIT;
                end
                else
                begin
                    state_next = ST_NEXT_WAIT;
                end
            end
            ST_NEXT_WAIT:
            begin
                state_next = ST_NEXT_DATA;
            end
            ST_NEXT_DATA:
            begin
                ticks_rem_next = ram_rd_data.ticks;
                state_next     = suppress ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    done_id_next     = res_id_reg;
                    done_bytes_next  = res_bytes_reg;
                    done_dir_next    = res_dir_reg;
                    done_status_next = res_status_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            ticks_rem_reg <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            ticks_rem_reg <= ticks_rem_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_q_reg       <= div_q_next;
        div_r_reg       <= div_r_next;
        div_d_reg       <= div_d_next;
        scaled_reg      <= scaled_next;
        id_hold_reg     <= id_hold_next;
        bytes_hold_reg  <= bytes_hold_next;
        res_id_reg      <= res_id_next;
        res_bytes_reg   <= res_bytes_next;
        res_dir_reg     <= res_dir_next;
        res_status_reg  <= res_status_next;
        done_id_reg     <= done_id_next;
        done_bytes_reg  <= done_bytes_next;
        done_dir_reg    <= done_dir_next;
        done_status_reg <= done_status_next;
    end

    assign out_valid      = out_valid_reg;
    assign done_id        = done_id_reg;
    assign done_bytes     = done_bytes_reg;
    assign done_direction = done_dir_reg;
    assign done_status    = done_status_reg;

`include "audio_buffer_playtime_queue_macros.svh"

    // The countdown runs exactly when the queue holds an entry.
    `ABPQ_ASSERT_ALWAYS(a_active_matches_count, active_reg == (count_reg != '0), "countdown state disagrees with queue fill")
    // A queue write never lands on a full queue.
    `ABPQ_ASSERT_IMPL(a_write_not_full, ram_wr_en, count_reg < FULL_COUNT, "queue written while full")
    // Retiring the head removes exactly one entry.
    `ABPQ_ASSERT_NEXT(a_head_retire, state_reg == ST_HEAD_DATA, (count_reg + 1'b1) == $past(count_reg), "head retirement did not drop one entry")
    // A result that leaves the sequencer shows up on the output.
    `ABPQ_ASSERT_NEXT(a_emit_visible, (state_reg == ST_EMIT) && !(out_valid_reg && out_stall), out_valid && (done_id == $past(res_id_reg)), "emitted result missing at output")

endmodule
